>>> hw/rtl/sicp_pkg.sv
// Shared types, element codes and parse states for the splice info section parser.
package sicp_pkg;

	localparam int MaxRec = 6;
	localparam int QDepth = 4;
	localparam int QPtrW  = 2;

	localparam logic [7:0] ResetTableId = 8'hFC;

	localparam logic [7:0] CMD_NULL     = 8'h00;
	localparam logic [7:0] CMD_SCHEDULE = 8'h04;
	localparam logic [7:0] CMD_INSERT   = 8'h05;
	localparam logic [7:0] CMD_TIME     = 8'h06;
	localparam logic [7:0] CMD_BANDW    = 8'h07;
	localparam logic [7:0] CMD_PRIVATE  = 8'hFF;

	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_TABLE_ID = 2'd1;
	localparam logic [1:0] ERR_SHORT    = 2'd2;

	localparam logic [5:0] FID_TABLE_ID = 6'd0;
	localparam logic [5:0] FID_SECTION_SYNTAX_INDICATOR = 6'd1;
	localparam logic [5:0] FID_PRIVATE_INDICATOR = 6'd2;
	localparam logic [5:0] FID_SECTION_LENGTH = 6'd3;
	localparam logic [5:0] FID_PROTOCOL_VERSION = 6'd4;
	localparam logic [5:0] FID_ENCRYPTED_PACKET = 6'd5;
	localparam logic [5:0] FID_ENCRYPTION_ALGORITHM = 6'd6;
	localparam logic [5:0] FID_TIME_OFFSET = 6'd7;
	localparam logic [5:0] FID_CW_INDEX = 6'd8;
	localparam logic [5:0] FID_TIER = 6'd9;
	localparam logic [5:0] FID_SPLICE_COMMAND_LENGTH = 6'd10;
	localparam logic [5:0] FID_SPLICE_COMMAND_TYPE = 6'd11;
	localparam logic [5:0] FID_SPLICE_EVENT_COUNT = 6'd12;
	localparam logic [5:0] FID_SPLICE_EVENT_ID = 6'd13;
	localparam logic [5:0] FID_SPLICE_EVENT_CANCEL_INDICATOR = 6'd14;
	localparam logic [5:0] FID_OUT_OF_NETWORK_INDICATOR = 6'd15;
	localparam logic [5:0] FID_PROGRAM_SPLICE_FLAG = 6'd16;
	localparam logic [5:0] FID_DURATION_FLAG = 6'd17;
	localparam logic [5:0] FID_SPLICE_IMMEDIATE_FLAG = 6'd18;
	localparam logic [5:0] FID_UTC_SPLICE_TIME = 6'd19;
	localparam logic [5:0] FID_COMPONENT_COUNT = 6'd20;
	localparam logic [5:0] FID_COMPONENT_TAG = 6'd21;
	localparam logic [5:0] FID_COMPONENT_UTC_SPLICE_TIME = 6'd22;
	localparam logic [5:0] FID_TIME_SPECIFIED_FLAG = 6'd23;
	localparam logic [5:0] FID_SPLICE_PTS = 6'd24;
	localparam logic [5:0] FID_ADJUSTED_SPLICE_PTS = 6'd25;
	localparam logic [5:0] FID_AUTO_RETURN = 6'd26;
	localparam logic [5:0] FID_BREAK_DURATION = 6'd27;
	localparam logic [5:0] FID_UNIQUE_PROGRAM_ID = 6'd28;
	localparam logic [5:0] FID_AVAIL_NUM = 6'd29;
	localparam logic [5:0] FID_AVAILS_EXPECTED = 6'd30;
	localparam logic [5:0] FID_PRIVATE_IDENTIFIER = 6'd31;
	localparam logic [5:0] FID_PRIVATE_BYTE = 6'd32;
	localparam logic [5:0] FID_DESCRIPTOR_LOOP_LENGTH = 6'd33;
	localparam logic [5:0] FID_SPLICE_DESCRIPTOR_TAG = 6'd34;
	localparam logic [5:0] FID_DESCRIPTOR_LENGTH = 6'd35;
	localparam logic [5:0] FID_DESCRIPTOR_IDENTIFIER = 6'd36;
	localparam logic [5:0] FID_DESCRIPTOR_PRIVATE_BYTE = 6'd37;
	localparam logic [5:0] FID_ALIGNMENT_STUFFING = 6'd38;
	localparam logic [5:0] FID_E_CRC_32 = 6'd39;
	localparam logic [5:0] FID_CRC_32 = 6'd40;
	localparam logic [5:0] FID_SECTION_ERROR = 6'd41;

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_HDR = 5'd1;
	localparam logic [4:0] S_PROTO = 5'd2;
	localparam logic [4:0] S_ENC = 5'd3;
	localparam logic [4:0] S_CW = 5'd4;
	localparam logic [4:0] S_TIERLEN = 5'd5;
	localparam logic [4:0] S_CTYPE = 5'd6;
	localparam logic [4:0] S_SKIP = 5'd7;
	localparam logic [4:0] S_SCOUNT = 5'd8;
	localparam logic [4:0] S_EVID = 5'd9;
	localparam logic [4:0] S_CANCEL = 5'd10;
	localparam logic [4:0] S_EVFLAGS = 5'd11;
	localparam logic [4:0] S_UTC = 5'd12;
	localparam logic [4:0] S_CCOUNT = 5'd13;
	localparam logic [4:0] S_CTAG = 5'd14;
	localparam logic [4:0] S_CUTC = 5'd15;
	localparam logic [4:0] S_TFLAG = 5'd16;
	localparam logic [4:0] S_TPTS = 5'd17;
	localparam logic [4:0] S_BRK = 5'd18;
	localparam logic [4:0] S_UPID = 5'd19;
	localparam logic [4:0] S_ANUM = 5'd20;
	localparam logic [4:0] S_AEXP = 5'd21;
	localparam logic [4:0] S_PID = 5'd22;
	localparam logic [4:0] S_PBYTE = 5'd23;
	localparam logic [4:0] S_DLOOP = 5'd24;
	localparam logic [4:0] S_DTAG = 5'd25;
	localparam logic [4:0] S_DLEN = 5'd26;
	localparam logic [4:0] S_DID = 5'd27;
	localparam logic [4:0] S_DPRIV = 5'd28;
	localparam logic [4:0] S_STUFF = 5'd29;
	localparam logic [4:0] S_ECRC = 5'd30;
	localparam logic [4:0] S_CRC = 5'd31;

	// splice flag bits
	localparam int F_PSF = 0;
	localparam int F_DUR = 1;
	localparam int F_IMM = 2;
	localparam int F_ENC = 3;

	typedef struct packed {
		logic        done;
		logic [1:0]  err;
		logic [7:0]  item;
		logic [7:0]  ev;
		logic [32:0] val;
		logic [5:0]  fid;
	} rec_t;

	typedef struct packed {
		logic [2:0]             cnt;
		rec_t [MaxRec-1:0]      recs;
	} bundle_t;

	function automatic logic [2:0] group_len(input logic [4:0] s);
		logic [2:0] r;
		case (s)
			S_HDR, S_UPID, S_DLOOP: r = 3'd2;
			S_TIERLEN: r = 3'd3;
			S_EVID, S_UTC, S_CUTC, S_TPTS, S_PID, S_DID, S_ECRC, S_CRC: r = 3'd4;
			S_ENC, S_BRK: r = 3'd5;
			S_IDLE: r = 3'd0;
			default: r = 3'd1;
		endcase
		return r;
	endfunction

	function automatic rec_t mk_rec(input logic [5:0] fid, input logic [32:0] val,
			input logic [7:0] ev, input logic [7:0] item, input logic [1:0] err,
			input logic done);
		rec_t r;
		r.fid = fid;
		r.val = val;
		r.ev = ev;
		r.item = item;
		r.err = err;
		r.done = done;
		return r;
	endfunction

endpackage

>>> hw/rtl/sicp_front.sv
// Byte parser: walks the section syntax one byte per cycle while in_fire is high and bundles its records.
module sicp_front import sicp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data,
	input  logic       in_fire,
	input  logic [7:0] in_byte,
	input  logic       in_start,
	output logic       push,
	output bundle_t    push_data
);

	logic [7:0]  exp_id_q;
	logic [4:0]  st_q;
	logic [11:0] bls_q;
	logic [39:0] acc_q;
	logic [2:0]  fbl_q;
	logic [7:0]  ctype_q;
	logic [11:0] cbl_q;
	logic [32:0] tadj_q;
	logic [3:0]  flg_q;
	logic [7:0]  ecl_q;
	logic [7:0]  ccl_q;
	logic [15:0] dlbl_q;
	logic [7:0]  dbl_q;
	logic [7:0]  hi_q;
	logic [7:0]  lo_q;

	logic [4:0]  st;
	logic [11:0] bls;
	logic [39:0] acc;
	logic [2:0]  fbl;
	logic [7:0]  ctype;
	logic [11:0] cbl;
	logic [32:0] tadj;
	logic [3:0]  flg;
	logic [7:0]  ecl;
	logic [7:0]  ccl;
	logic [15:0] dlbl;
	logic [7:0]  dbl;
	logic [7:0]  hi;
	logic [7:0]  lo;
	rec_t [MaxRec-1:0] recs;
	logic [2:0]  n;

	always_comb begin
		logic        ent;
		logic [4:0]  nx;
		logic        go;
		logic        ins;
		logic [7:0]  ev;
		logic [7:0]  titem;
		logic [7:0]  d;
		logic [32:0] bv;
		logic [3:0]  tail;
		logic        psf;
		logic        dur;
		logic        imm;
		st = st_q; bls = bls_q; acc = acc_q; fbl = fbl_q; ctype = ctype_q;
		cbl = cbl_q; tadj = tadj_q; flg = flg_q; ecl = ecl_q; ccl = ccl_q;
		dlbl = dlbl_q; dbl = dbl_q; hi = hi_q; lo = lo_q;
		recs = '0;
		n = 3'd0;
		ent = 1'b0;
		nx = S_IDLE;
		go = 1'b0;
		bv = {25'd0, in_byte};
		ins = (ctype_q == CMD_INSERT);
		ev = hi_q;
		titem = (ins && !flg_q[F_PSF]) ? lo_q : 8'd0;
		d = hi_q;
		tail = flg_q[F_ENC] ? 4'd8 : 4'd4;
		psf = in_byte[6];
		dur = in_byte[5];
		imm = ins & in_byte[4];
		if (in_fire) begin
			if (in_start) begin
				if (st_q != S_IDLE) begin
					recs[n] = mk_rec(FID_SECTION_ERROR, '0, 8'd0, 8'd0, ERR_SHORT, 1'b1);
					n = n + 3'd1;
				end
				st = S_IDLE; bls = '0; acc = '0; fbl = '0; ctype = '0; cbl = '0;
				tadj = '0; flg = '0; ecl = '0; ccl = '0; dlbl = '0; dbl = '0;
				hi = '0; lo = '0;
				if (in_byte != exp_id_q) begin
					recs[n] = mk_rec(FID_TABLE_ID, bv, 8'd0, 8'd0, ERR_TABLE_ID, 1'b1);
					n = n + 3'd1;
				end else begin
					recs[n] = mk_rec(FID_TABLE_ID, bv, 8'd0, 8'd0, ERR_NONE, 1'b0);
					n = n + 3'd1;
					st = S_HDR;
					fbl = group_len(S_HDR);
				end
			end else if (st_q != S_IDLE) begin
				if (st_q != S_HDR) bls = bls - 12'd1;
				if (st_q == S_DTAG || st_q == S_DLEN || st_q == S_DID || st_q == S_DPRIV) begin
					dlbl = dlbl - 16'd1;
					case (st_q)
						S_DTAG: begin
							recs[n] = mk_rec(FID_SPLICE_DESCRIPTOR_TAG, bv, 8'd0, d, ERR_NONE, 1'b0);
							n = n + 3'd1;
							ent = 1'b1; nx = S_DLEN;
						end
						S_DLEN: begin
							recs[n] = mk_rec(FID_DESCRIPTOR_LENGTH, bv, 8'd0, d, ERR_NONE, 1'b0);
							n = n + 3'd1;
							dbl = in_byte;
							ent = 1'b1;
							if (in_byte == 8'd0) begin
								hi = hi + 8'd1; lo = 8'd0; nx = S_DTAG;
							end else begin
								nx = S_DID;
							end
						end
						S_DID: begin
							acc = {acc[31:0], in_byte};
							dbl = dbl - 8'd1;
							if (fbl != 3'd0) fbl = fbl - 3'd1;
							if (fbl == 3'd0) begin
								recs[n] = mk_rec(FID_DESCRIPTOR_IDENTIFIER, {1'b0, acc[31:0]},
									8'd0, d, ERR_NONE, 1'b0);
								n = n + 3'd1;
								ent = 1'b1;
								if (dbl == 8'd0) begin
									hi = hi + 8'd1; lo = 8'd0; nx = S_DTAG;
								end else begin
									lo = 8'd0; nx = S_DPRIV;
								end
							end else if (dbl == 8'd0) begin
								hi = hi + 8'd1; lo = 8'd0; ent = 1'b1; nx = S_DTAG;
							end
						end
						default: begin
							recs[n] = mk_rec(FID_DESCRIPTOR_PRIVATE_BYTE, bv, 8'd0, lo, ERR_NONE, 1'b0);
							n = n + 3'd1;
							lo = lo + 8'd1;
							dbl = dbl - 8'd1;
							if (dbl == 8'd0) begin
								hi = hi + 8'd1; lo = 8'd0; ent = 1'b1; nx = S_DTAG;
							end
						end
					endcase
					if (dlbl == 16'd0) begin
						ent = 1'b1; nx = S_STUFF;
					end
				end else begin
					go = 1'b1;
					if (st_q == S_STUFF) begin
						if (bls >= {8'd0, tail}) begin
							recs[n] = mk_rec(FID_ALIGNMENT_STUFFING, bv, 8'd0, 8'd0, ERR_NONE, 1'b0);
							n = n + 3'd1;
							go = 1'b0;
						end else begin
							st = flg[F_ENC] ? S_ECRC : S_CRC;
							fbl = group_len(st);
							acc = '0;
						end
					end
					if (go) begin
						acc = {acc[31:0], in_byte};
						if (fbl > 3'd1) begin
							fbl = fbl - 3'd1;
						end else begin
							fbl = 3'd0;
							ent = 1'b1;
							case (st)
								S_HDR: begin
									recs[n] = mk_rec(FID_SECTION_SYNTAX_INDICATOR, {32'd0, acc[15]},
										8'd0, 8'd0, ERR_NONE, 1'b0);
									recs[n+3'd1] = mk_rec(FID_PRIVATE_INDICATOR, {32'd0, acc[14]},
										8'd0, 8'd0, ERR_NONE, 1'b0);
									recs[n+3'd2] = mk_rec(FID_SECTION_LENGTH, {21'd0, acc[11:0]},
										8'd0, 8'd0, ERR_NONE, 1'b0);
									n = n + 3'd3;
									bls = acc[11:0];
									nx = S_PROTO;
								end
								S_PROTO: begin
									recs[n] = mk_rec(FID_PROTOCOL_VERSION, bv, 8'd0, 8'd0, ERR_NONE, 1'b0);
									n = n + 3'd1;
									nx = S_ENC;
								end
								S_ENC: begin
									recs[n] = mk_rec(FID_ENCRYPTED_PACKET, {32'd0, acc[39]},
										8'd0, 8'd0, ERR_NONE, 1'b0);
									recs[n+3'd1] = mk_rec(FID_ENCRYPTION_ALGORITHM, {27'd0, acc[38:33]},
										8'd0, 8'd0, ERR_NONE, 1'b0);
									recs[n+3'd2] = mk_rec(FID_TIME_OFFSET, acc[32:0],
										8'd0, 8'd0, ERR_NONE, 1'b0);
									n = n + 3'd3;
									tadj = acc[32:0];
									flg = {acc[39], 3'b000};
									nx = S_CW;
								end
								S_CW: begin
									recs[n] = mk_rec(FID_CW_INDEX, bv, 8'd0, 8'd0, ERR_NONE, 1'b0);
									n = n + 3'd1;
									nx = S_TIERLEN;
								end
								S_TIERLEN: begin
									recs[n] = mk_rec(FID_TIER, {21'd0, acc[23:12]},
										8'd0, 8'd0, ERR_NONE, 1'b0);
									recs[n+3'd1] = mk_rec(FID_SPLICE_COMMAND_LENGTH, {21'd0, acc[11:0]},
										8'd0, 8'd0, ERR_NONE, 1'b0);
									n = n + 3'd2;
									cbl = acc[11:0];
									nx = S_CTYPE;
								end
								S_CTYPE: begin
									recs[n] = mk_rec(FID_SPLICE_COMMAND_TYPE, bv, 8'd0, 8'd0, ERR_NONE, 1'b0);
									n = n + 3'd1;
									ctype = in_byte;
									flg = flg & 4'b1000;
									hi = 8'd0; lo = 8'd0;
									if (in_byte == CMD_NULL || in_byte == CMD_BANDW) nx = S_DLOOP;
									else if (in_byte == CMD_SCHEDULE) nx = S_SCOUNT;
									else if (in_byte == CMD_INSERT) nx = S_EVID;
									else if (in_byte == CMD_TIME) nx = S_TFLAG;
									else if (in_byte == CMD_PRIVATE) nx = S_PID;
									else nx = (cbl != 12'd0) ? S_SKIP : S_DLOOP;
								end
								S_SKIP: begin
									cbl = cbl - 12'd1;
									nx = (cbl != 12'd0) ? S_SKIP : S_DLOOP;
								end
								S_SCOUNT: begin
									recs[n] = mk_rec(FID_SPLICE_EVENT_COUNT, bv, 8'd0, 8'd0, ERR_NONE, 1'b0);
									n = n + 3'd1;
									ecl = in_byte;
									nx = (in_byte != 8'd0) ? S_EVID : S_DLOOP;
								end
								S_EVID: begin
									recs[n] = mk_rec(FID_SPLICE_EVENT_ID, {1'b0, acc[31:0]},
										ev, 8'd0, ERR_NONE, 1'b0);
									n = n + 3'd1;
									nx = S_CANCEL;
								end
								S_CANCEL: begin
									recs[n] = mk_rec(FID_SPLICE_EVENT_CANCEL_INDICATOR,
										{32'd0, in_byte[7]}, ev, 8'd0, ERR_NONE, 1'b0);
									n = n + 3'd1;
									flg = flg & 4'b1000;
									nx = in_byte[7] ? S_UPID : S_EVFLAGS;
								end
								S_EVFLAGS: begin
									recs[n] = mk_rec(FID_OUT_OF_NETWORK_INDICATOR, {32'd0, in_byte[7]},
										ev, 8'd0, ERR_NONE, 1'b0);
									recs[n+3'd1] = mk_rec(FID_PROGRAM_SPLICE_FLAG, {32'd0, psf},
										ev, 8'd0, ERR_NONE, 1'b0);
									recs[n+3'd2] = mk_rec(FID_DURATION_FLAG, {32'd0, dur},
										ev, 8'd0, ERR_NONE, 1'b0);
									n = n + 3'd3;
									if (ins) begin
										recs[n] = mk_rec(FID_SPLICE_IMMEDIATE_FLAG, {32'd0, imm},
											ev, 8'd0, ERR_NONE, 1'b0);
										n = n + 3'd1;
									end
									flg = {flg[F_ENC], imm, dur, psf};
									if (!psf) nx = S_CCOUNT;
									else if (!ins) nx = S_UTC;
									else if (!imm) nx = S_TFLAG;
									else nx = dur ? S_BRK : S_UPID;
								end
								S_UTC: begin
									recs[n] = mk_rec(FID_UTC_SPLICE_TIME, {1'b0, acc[31:0]},
										ev, 8'd0, ERR_NONE, 1'b0);
									n = n + 3'd1;
									nx = flg[F_DUR] ? S_BRK : S_UPID;
								end
								S_CCOUNT: begin
									recs[n] = mk_rec(FID_COMPONENT_COUNT, bv, ev, 8'd0, ERR_NONE, 1'b0);
									n = n + 3'd1;
									ccl = in_byte;
									lo = 8'd0;
									if (in_byte == 8'd0) nx = flg[F_DUR] ? S_BRK : S_UPID;
									else nx = S_CTAG;
								end
								S_CTAG: begin
									recs[n] = mk_rec(FID_COMPONENT_TAG, bv, ev, lo, ERR_NONE, 1'b0);
									n = n + 3'd1;
									if (!ins) nx = S_CUTC;
									else if (!flg[F_IMM]) nx = S_TFLAG;
									else begin
										lo = lo + 8'd1;
										ccl = ccl - 8'd1;
										if (ccl == 8'd0) nx = flg[F_DUR] ? S_BRK : S_UPID;
										else nx = S_CTAG;
									end
								end
								S_CUTC: begin
									recs[n] = mk_rec(FID_COMPONENT_UTC_SPLICE_TIME, {1'b0, acc[31:0]},
										ev, lo, ERR_NONE, 1'b0);
									n = n + 3'd1;
									lo = lo + 8'd1;
									ccl = ccl - 8'd1;
									if (ccl == 8'd0) nx = flg[F_DUR] ? S_BRK : S_UPID;
									else nx = S_CTAG;
								end
								S_TFLAG, S_TPTS: begin
									if (st == S_TFLAG) begin
										recs[n] = mk_rec(FID_TIME_SPECIFIED_FLAG, {32'd0, in_byte[7]},
											8'd0, titem, ERR_NONE, 1'b0);
									end else begin
										recs[n] = mk_rec(FID_SPLICE_PTS, acc[32:0], 8'd0, titem,
											ERR_NONE, 1'b0);
									end
									n = n + 3'd1;
									if (st == S_TPTS && ins && flg[F_PSF]) begin
										recs[n] = mk_rec(FID_ADJUSTED_SPLICE_PTS, acc[32:0] + tadj,
											8'd0, 8'd0, ERR_NONE, 1'b0);
										n = n + 3'd1;
									end
									if (st == S_TFLAG && in_byte[7]) begin
										// pts keeps the flag byte's low bit as its top bit
										ent = 1'b0;
										st = S_TPTS;
										fbl = 3'd4;
									end else if (!ins) begin
										nx = S_DLOOP;
									end else if (flg[F_PSF]) begin
										nx = flg[F_DUR] ? S_BRK : S_UPID;
									end else begin
										lo = lo + 8'd1;
										ccl = ccl - 8'd1;
										if (ccl == 8'd0) nx = flg[F_DUR] ? S_BRK : S_UPID;
										else nx = S_CTAG;
									end
								end
								S_BRK: begin
									recs[n] = mk_rec(FID_AUTO_RETURN, {32'd0, acc[39]},
										ev, 8'd0, ERR_NONE, 1'b0);
									recs[n+3'd1] = mk_rec(FID_BREAK_DURATION, acc[32:0],
										ev, 8'd0, ERR_NONE, 1'b0);
									n = n + 3'd2;
									nx = S_UPID;
								end
								S_UPID: begin
									recs[n] = mk_rec(FID_UNIQUE_PROGRAM_ID, {17'd0, acc[15:0]},
										ev, 8'd0, ERR_NONE, 1'b0);
									n = n + 3'd1;
									nx = S_ANUM;
								end
								S_ANUM: begin
									recs[n] = mk_rec(FID_AVAIL_NUM, bv, ev, 8'd0, ERR_NONE, 1'b0);
									n = n + 3'd1;
									nx = S_AEXP;
								end
								S_AEXP: begin
									recs[n] = mk_rec(FID_AVAILS_EXPECTED, bv, ev, 8'd0, ERR_NONE, 1'b0);
									n = n + 3'd1;
									nx = S_DLOOP;
									if (ctype == CMD_SCHEDULE) begin
										hi = ev + 8'd1;
										ecl = ecl - 8'd1;
										if (ecl != 8'd0) begin
											lo = 8'd0;
											nx = S_EVID;
										end
									end
								end
								S_PID: begin
									recs[n] = mk_rec(FID_PRIVATE_IDENTIFIER, {1'b0, acc[31:0]},
										8'd0, 8'd0, ERR_NONE, 1'b0);
									n = n + 3'd1;
									cbl = (cbl > 12'd4) ? cbl - 12'd4 : 12'd0;
									lo = 8'd0;
									nx = (cbl != 12'd0) ? S_PBYTE : S_DLOOP;
								end
								S_PBYTE: begin
									recs[n] = mk_rec(FID_PRIVATE_BYTE, bv, 8'd0, lo, ERR_NONE, 1'b0);
									n = n + 3'd1;
									lo = lo + 8'd1;
									cbl = cbl - 12'd1;
									nx = (cbl != 12'd0) ? S_PBYTE : S_DLOOP;
								end
								S_DLOOP: begin
									recs[n] = mk_rec(FID_DESCRIPTOR_LOOP_LENGTH, {17'd0, acc[15:0]},
										8'd0, 8'd0, ERR_NONE, 1'b0);
									n = n + 3'd1;
									dlbl = acc[15:0];
									hi = 8'd0; lo = 8'd0;
									nx = (dlbl != 16'd0) ? S_DTAG : S_STUFF;
								end
								S_ECRC: begin
									recs[n] = mk_rec(FID_E_CRC_32, {1'b0, acc[31:0]},
										8'd0, 8'd0, ERR_NONE, 1'b0);
									n = n + 3'd1;
									nx = S_CRC;
								end
								S_CRC: begin
									recs[n] = mk_rec(FID_CRC_32, {1'b0, acc[31:0]},
										8'd0, 8'd0, ERR_NONE, 1'b1);
									n = n + 3'd1;
									nx = S_IDLE;
								end
								default: nx = S_IDLE;
							endcase
						end
					end
				end
				if (ent) begin
					st = nx;
					fbl = group_len(nx);
					acc = '0;
				end
				if (st != S_IDLE && st != S_HDR && bls == 12'd0) begin
					recs[n] = mk_rec(FID_SECTION_ERROR, '0, 8'd0, 8'd0, ERR_SHORT, 1'b1);
					n = n + 3'd1;
					st = S_IDLE; bls = '0; acc = '0; fbl = '0; ctype = '0; cbl = '0;
					tadj = '0; flg = '0; ecl = '0; ccl = '0; dlbl = '0; dbl = '0;
					hi = '0; lo = '0;
				end
			end
		end
	end

	assign push = in_fire && (n != 3'd0);
	assign push_data.cnt = n;
	assign push_data.recs = recs;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_id_q <= ResetTableId;
			st_q <= S_IDLE; bls_q <= '0; acc_q <= '0; fbl_q <= '0; ctype_q <= '0;
			cbl_q <= '0; tadj_q <= '0; flg_q <= '0; ecl_q <= '0; ccl_q <= '0;
			dlbl_q <= '0; dbl_q <= '0; hi_q <= '0; lo_q <= '0;
		end else begin
			if (cfg_wr_en) exp_id_q <= cfg_wr_data;
			if (in_fire) begin
				st_q <= st; bls_q <= bls; acc_q <= acc; fbl_q <= fbl; ctype_q <= ctype;
				cbl_q <= cbl; tadj_q <= tadj; flg_q <= flg; ecl_q <= ecl; ccl_q <= ccl;
				dlbl_q <= dlbl; dbl_q <= dbl; hi_q <= hi; lo_q <= lo;
			end
		end
	end

endmodule

>>> hw/rtl/sicp_queue.sv
// Short queue of record bundles between the parser and the record sender.
module sicp_queue import sicp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  bundle_t push_data,
	output logic    full,
	output logic    not_empty,
	input  logic    pop,
	output bundle_t pop_data
);

	bundle_t            mem_q [QDepth];
	logic [QPtrW-1:0]   wr_q;
	logic [QPtrW-1:0]   rd_q;
	logic [QPtrW:0]     cnt_q;

	assign full = (cnt_q == (QPtrW+1)'(QDepth));
	assign not_empty = (cnt_q != '0);
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (QPtrW+1)'(push) - (QPtrW+1)'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push || pop)
		else $error("queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("queue underflow");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (QPtrW+1)'(QDepth))
		else $error("queue count out of range");
	a_bundle_size: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> push_data.cnt <= 3'(MaxRec))
		else $error("bundle larger than record limit");

endmodule

>>> hw/rtl/sicp_back.sv
// Record sender: unpacks bundles and drives one record per transaction.
module sicp_back import sicp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	input  bundle_t     q_data,
	output logic        q_pop,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata
);

	rec_t [MaxRec-1:0] cur_q;
	logic [2:0]        cnt_q;
	logic [2:0]        idx_q;
	rec_t              out_q;
	logic              valid_q;
	logic              free;
	logic              have;
	logic              last;

	assign free = !valid_q || m_tready;
	assign have = (idx_q != cnt_q);
	assign last = have && free && (idx_q + 3'd1 == cnt_q);
	assign q_pop = q_valid && (!have || last);

	assign m_tvalid = valid_q;
	assign m_tdata = {6'd0, out_q.done, out_q.err, out_q.item, out_q.ev, out_q.val, out_q.fid};

	always_ff @(posedge clk) begin
		if (free && have) out_q <= cur_q[idx_q];
		if (q_pop) cur_q <= q_data.recs;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			cnt_q <= '0;
			idx_q <= '0;
		end else begin
			if (free) valid_q <= have;
			if (q_pop) begin
				cnt_q <= q_data.cnt;
				idx_q <= '0;
			end else if (free && have) begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= cnt_q)
		else $error("record index past bundle end");
	a_pop_only_drained: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !have || last)
		else $error("bundle loaded over pending records");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'(MaxRec))
		else $error("bundle count out of range");

endmodule

>>> hw/rtl/splice_info_section_parser_unit.sv
// Splice info section parser top level: parser, bundle queue and record sender.
//
//  channel  | dir | handshake         | payload
//  s_*      | in  | s_tvalid/s_tready | tdata: data_byte; tuser: section_start
//  m_*      | out | m_tvalid/m_tready | tdata: record fields, see port comment
//  cfg_*    | in  | cfg_wr_en         | expected_table_id
//
// One section byte is taken per cycle while the 4-deep bundle queue has room.
// Each byte yields 0 to 6 records; the sender drives one record per cycle while m_tready is high,
// so sustained byte rate follows the record count.
// Reset clears parse state, queue and output; expected_table_id resets to 0xFC.
// Either side may stall freely; the queue decouples parser from sender.
module splice_info_section_parser_unit import sicp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic [0:0]  s_tuser,   // [0] section_start
	output logic        m_tvalid,
	input  logic        m_tready,
	// [5:0] field_id, [38:6] field_value, [46:39] event_index,
	// [54:47] item_index, [56:55] error_code, [57] section_done, rest zero
	output logic [63:0] m_tdata
);

	logic    q_full;
	logic    q_valid;
	logic    q_pop;
	logic    push;
	bundle_t push_data;
	bundle_t q_data;

	assign s_tready = !q_full;

	sicp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_fire    (s_tvalid && s_tready),
		.in_byte    (s_tdata),
		.in_start   (s_tuser[0]),
		.push       (push),
		.push_data  (push_data)
	);

	sicp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.full     (q_full),
		.not_empty(q_valid),
		.pop      (q_pop),
		.pop_data (q_data)
	);

	sicp_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_data  (q_data),
		.q_pop   (q_pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

endmodule

>>> bench/splice_info_section_parser_unit_tb.sv
// Self-checking testbench for the splice info section parser: section streams against a predictor.
`timescale 1ns / 100ps

module splice_info_section_parser_unit_tb;
	import sicp_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [7:0]  cfg_wr_data = ResetTableId;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;
	logic [0:0]  s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;

	splice_info_section_parser_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		#(12 * 400000);
		$display("FAILURE");
		$finish;
	end

	// ---------------- section parser predictor ----------------
	logic [7:0]  p_tid = ResetTableId;
	logic [4:0]  ps;
	logic [11:0] sec_left;
	logic [39:0] acc;
	logic [2:0]  fbl;
	logic [7:0]  cmd_type;
	logic [11:0] cmd_left;
	logic [32:0] pts_adj;
	logic [3:0]  sflags;
	logic [7:0]  ev_left;
	logic [7:0]  comp_left;
	logic [15:0] dloop_left;
	logic [7:0]  desc_left;
	logic [7:0]  idx_hi;
	logic [7:0]  idx_lo;

	rec_t batch[$];
	rec_t expected_recs[$];
	int   errs = 0;

	function automatic logic [2:0] span_of(logic [4:0] s);
		case (s)
			S_IDLE: return 3'd0;
			S_HDR, S_UPID, S_DLOOP: return 3'd2;
			S_TIERLEN: return 3'd3;
			S_EVID, S_UTC, S_CUTC, S_TPTS, S_PID, S_DID, S_ECRC, S_CRC: return 3'd4;
			S_ENC, S_BRK: return 3'd5;
			default: return 3'd1;
		endcase
	endfunction

	function automatic void emit(logic [5:0] fid, logic [32:0] v, logic [7:0] ev,
			logic [7:0] item, logic [1:0] err, logic done);
		rec_t r;
		if (batch.size() < MaxRec) begin
			r = '{done, err, item, ev, v, fid};
			batch.push_back(r);
		end
	endfunction

	function automatic void goto(logic [4:0] s);
		ps = s;
		fbl = span_of(s);
		acc = '0;
	endfunction

	function automatic void clear_parse();
		ps = S_IDLE; sec_left = '0; acc = '0; fbl = '0; cmd_type = '0; cmd_left = '0;
		pts_adj = '0; sflags = '0; ev_left = '0; comp_left = '0; dloop_left = '0;
		desc_left = '0; idx_hi = '0; idx_lo = '0;
	endfunction

	function automatic void after_main();
		goto(sflags[F_DUR] ? S_BRK : S_UPID);
	endfunction

	function automatic void comp_next();
		idx_lo = idx_lo + 8'd1;
		comp_left = comp_left - 8'd1;
		if (comp_left == 0) after_main();
		else goto(S_CTAG);
	endfunction

	function automatic void after_time();
		if (cmd_type != CMD_INSERT) goto(S_DLOOP);
		else if (sflags[F_PSF]) after_main();
		else comp_next();
	endfunction

	function automatic void desc_next();
		idx_hi = idx_hi + 8'd1;
		idx_lo = '0;
		goto(S_DTAG);
	endfunction

	function automatic void desc_byte(logic [7:0] b);
		logic [7:0] d;
		d = idx_hi;
		dloop_left = dloop_left - 16'd1;
		case (ps)
			S_DTAG: begin
				emit(FID_SPLICE_DESCRIPTOR_TAG, b, 0, d, ERR_NONE, 0);
				goto(S_DLEN);
			end
			S_DLEN: begin
				emit(FID_DESCRIPTOR_LENGTH, b, 0, d, ERR_NONE, 0);
				desc_left = b;
				if (b == 0) desc_next(); else goto(S_DID);
			end
			S_DID: begin
				acc = {acc[31:0], b};
				desc_left = desc_left - 8'd1;
				if (fbl > 0) fbl = fbl - 3'd1;
				if (fbl == 0) begin
					emit(FID_DESCRIPTOR_IDENTIFIER, acc[31:0], 0, d, ERR_NONE, 0);
					if (desc_left == 0) desc_next();
					else begin
						idx_lo = '0;
						goto(S_DPRIV);
					end
				end else if (desc_left == 0) begin
					desc_next();
				end
			end
			default: begin
				emit(FID_DESCRIPTOR_PRIVATE_BYTE, b, 0, idx_lo, ERR_NONE, 0);
				idx_lo = idx_lo + 8'd1;
				desc_left = desc_left - 8'd1;
				if (desc_left == 0) desc_next();
			end
		endcase
		if (dloop_left == 0) goto(S_STUFF);
	endfunction

	function automatic void finish_field(logic [7:0] b);
		logic [39:0] a;
		logic [7:0]  ev;
		logic        ins;
		logic [7:0]  titem;
		logic        psf, dur, imm;
		a = acc;
		ev = idx_hi;
		ins = (cmd_type == CMD_INSERT);
		titem = (ins && !sflags[F_PSF]) ? idx_lo : 8'd0;
		case (ps)
			S_HDR: begin
				emit(FID_SECTION_SYNTAX_INDICATOR, a[15], 0, 0, ERR_NONE, 0);
				emit(FID_PRIVATE_INDICATOR, a[14], 0, 0, ERR_NONE, 0);
				emit(FID_SECTION_LENGTH, a[11:0], 0, 0, ERR_NONE, 0);
				sec_left = a[11:0];
				goto(S_PROTO);
			end
			S_PROTO: begin
				emit(FID_PROTOCOL_VERSION, b, 0, 0, ERR_NONE, 0);
				goto(S_ENC);
			end
			S_ENC: begin
				emit(FID_ENCRYPTED_PACKET, a[39], 0, 0, ERR_NONE, 0);
				emit(FID_ENCRYPTION_ALGORITHM, a[38:33], 0, 0, ERR_NONE, 0);
				emit(FID_TIME_OFFSET, a[32:0], 0, 0, ERR_NONE, 0);
				pts_adj = a[32:0];
				sflags = '0;
				sflags[F_ENC] = a[39];
				goto(S_CW);
			end
			S_CW: begin
				emit(FID_CW_INDEX, b, 0, 0, ERR_NONE, 0);
				goto(S_TIERLEN);
			end
			S_TIERLEN: begin
				emit(FID_TIER, a[23:12], 0, 0, ERR_NONE, 0);
				emit(FID_SPLICE_COMMAND_LENGTH, a[11:0], 0, 0, ERR_NONE, 0);
				cmd_left = a[11:0];
				goto(S_CTYPE);
			end
			S_CTYPE: begin
				emit(FID_SPLICE_COMMAND_TYPE, b, 0, 0, ERR_NONE, 0);
				cmd_type = b;
				sflags = sflags & (4'd1 << F_ENC);
				idx_hi = '0;
				idx_lo = '0;
				if (b == CMD_NULL || b == CMD_BANDW) goto(S_DLOOP);
				else if (b == CMD_SCHEDULE) goto(S_SCOUNT);
				else if (b == CMD_INSERT) goto(S_EVID);
				else if (b == CMD_TIME) goto(S_TFLAG);
				else if (b == CMD_PRIVATE) goto(S_PID);
				else goto(cmd_left != 0 ? S_SKIP : S_DLOOP);
			end
			S_SKIP: begin
				cmd_left = cmd_left - 12'd1;
				goto(cmd_left == 0 ? S_DLOOP : S_SKIP);
			end
			S_SCOUNT: begin
				emit(FID_SPLICE_EVENT_COUNT, b, 0, 0, ERR_NONE, 0);
				ev_left = b;
				goto(b != 0 ? S_EVID : S_DLOOP);
			end
			S_EVID: begin
				emit(FID_SPLICE_EVENT_ID, a[31:0], ev, 0, ERR_NONE, 0);
				goto(S_CANCEL);
			end
			S_CANCEL: begin
				emit(FID_SPLICE_EVENT_CANCEL_INDICATOR, b[7], ev, 0, ERR_NONE, 0);
				sflags = sflags & (4'd1 << F_ENC);
				goto(b[7] ? S_UPID : S_EVFLAGS);
			end
			S_EVFLAGS: begin
				psf = b[6];
				dur = b[5];
				imm = ins ? b[4] : 1'b0;
				emit(FID_OUT_OF_NETWORK_INDICATOR, b[7], ev, 0, ERR_NONE, 0);
				emit(FID_PROGRAM_SPLICE_FLAG, psf, ev, 0, ERR_NONE, 0);
				emit(FID_DURATION_FLAG, dur, ev, 0, ERR_NONE, 0);
				if (ins) emit(FID_SPLICE_IMMEDIATE_FLAG, imm, ev, 0, ERR_NONE, 0);
				sflags[F_PSF] = psf;
				sflags[F_DUR] = dur;
				sflags[F_IMM] = imm;
				if (!psf) goto(S_CCOUNT);
				else if (!ins) goto(S_UTC);
				else if (!imm) goto(S_TFLAG);
				else after_main();
			end
			S_UTC: begin
				emit(FID_UTC_SPLICE_TIME, a[31:0], ev, 0, ERR_NONE, 0);
				after_main();
			end
			S_CCOUNT: begin
				emit(FID_COMPONENT_COUNT, b, ev, 0, ERR_NONE, 0);
				comp_left = b;
				idx_lo = '0;
				if (b == 0) after_main(); else goto(S_CTAG);
			end
			S_CTAG: begin
				emit(FID_COMPONENT_TAG, b, ev, idx_lo, ERR_NONE, 0);
				if (!ins) goto(S_CUTC);
				else if (!sflags[F_IMM]) goto(S_TFLAG);
				else comp_next();
			end
			S_CUTC: begin
				emit(FID_COMPONENT_UTC_SPLICE_TIME, a[31:0], ev, idx_lo, ERR_NONE, 0);
				comp_next();
			end
			S_TFLAG: begin
				emit(FID_TIME_SPECIFIED_FLAG, b[7], 0, titem, ERR_NONE, 0);
				// the splice pts keeps the flag byte in the accumulator
				if (b[7]) begin
					ps = S_TPTS;
					fbl = 3'd4;
				end else begin
					after_time();
				end
			end
			S_TPTS: begin
				emit(FID_SPLICE_PTS, a[32:0], 0, titem, ERR_NONE, 0);
				if (ins && sflags[F_PSF])
					emit(FID_ADJUSTED_SPLICE_PTS, a[32:0] + pts_adj, 0, 0, ERR_NONE, 0);
				after_time();
			end
			S_BRK: begin
				emit(FID_AUTO_RETURN, a[39], ev, 0, ERR_NONE, 0);
				emit(FID_BREAK_DURATION, a[32:0], ev, 0, ERR_NONE, 0);
				goto(S_UPID);
			end
			S_UPID: begin
				emit(FID_UNIQUE_PROGRAM_ID, a[15:0], ev, 0, ERR_NONE, 0);
				goto(S_ANUM);
			end
			S_ANUM: begin
				emit(FID_AVAIL_NUM, b, ev, 0, ERR_NONE, 0);
				goto(S_AEXP);
			end
			S_AEXP: begin
				emit(FID_AVAILS_EXPECTED, b, ev, 0, ERR_NONE, 0);
				if (cmd_type == CMD_SCHEDULE) begin
					idx_hi = ev + 8'd1;
					ev_left = ev_left - 8'd1;
					if (ev_left == 0) goto(S_DLOOP);
					else begin
						idx_lo = '0;
						goto(S_EVID);
					end
				end else begin
					goto(S_DLOOP);
				end
			end
			S_PID: begin
				emit(FID_PRIVATE_IDENTIFIER, a[31:0], 0, 0, ERR_NONE, 0);
				cmd_left = (cmd_left > 12'd4) ? cmd_left - 12'd4 : 12'd0;
				idx_lo = '0;
				goto(cmd_left != 0 ? S_PBYTE : S_DLOOP);
			end
			S_PBYTE: begin
				emit(FID_PRIVATE_BYTE, b, 0, idx_lo, ERR_NONE, 0);
				idx_lo = idx_lo + 8'd1;
				cmd_left = cmd_left - 12'd1;
				goto(cmd_left != 0 ? S_PBYTE : S_DLOOP);
			end
			S_DLOOP: begin
				emit(FID_DESCRIPTOR_LOOP_LENGTH, a[15:0], 0, 0, ERR_NONE, 0);
				dloop_left = a[15:0];
				idx_hi = '0;
				idx_lo = '0;
				goto(dloop_left != 0 ? S_DTAG : S_STUFF);
			end
			S_ECRC: begin
				emit(FID_E_CRC_32, a[31:0], 0, 0, ERR_NONE, 0);
				goto(S_CRC);
			end
			S_CRC: begin
				emit(FID_CRC_32, a[31:0], 0, 0, ERR_NONE, 1);
				goto(S_IDLE);
			end
			default: goto(S_IDLE);
		endcase
	endfunction

	function automatic void take_byte(logic [7:0] b);
		logic [11:0] tail;
		if (ps == S_DTAG || ps == S_DLEN || ps == S_DID || ps == S_DPRIV) begin
			desc_byte(b);
			return;
		end
		if (ps == S_STUFF) begin
			tail = sflags[F_ENC] ? 12'd8 : 12'd4;
			if (sec_left >= tail) begin
				emit(FID_ALIGNMENT_STUFFING, b, 0, 0, ERR_NONE, 0);
				return;
			end
			goto(sflags[F_ENC] ? S_ECRC : S_CRC);
		end
		acc = {acc[31:0], b};
		if (fbl > 1) begin
			fbl = fbl - 3'd1;
			return;
		end
		fbl = '0;
		finish_field(b);
	endfunction

	function automatic void parse_byte(logic [7:0] b, logic st);
		batch.delete();
		if (st) begin
			if (ps != S_IDLE) emit(FID_SECTION_ERROR, 0, 0, 0, ERR_SHORT, 1);
			clear_parse();
			if (b != p_tid) emit(FID_TABLE_ID, b, 0, 0, ERR_TABLE_ID, 1);
			else begin
				emit(FID_TABLE_ID, b, 0, 0, ERR_NONE, 0);
				goto(S_HDR);
			end
			return;
		end
		if (ps == S_IDLE) return;
		if (ps != S_HDR) sec_left = sec_left - 12'd1;
		take_byte(b);
		if (ps != S_IDLE && ps != S_HDR && sec_left == 0) begin
			emit(FID_SECTION_ERROR, 0, 0, 0, ERR_SHORT, 1);
			clear_parse();
		end
	endfunction

	// ---------------- stream drivers ----------------
	bit calm = 1'b0;
	bit hold_req = 1'b0;
	int hold_left = 0;

	function automatic bit idle_roll();
		return !calm && ($urandom_range(99) < 17);
	endfunction

	task automatic send_byte(logic [7:0] b, logic st, bit typed, rec_t typed_rec);
		while (idle_roll()) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tuser <= st;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		parse_byte(b, st);
		if (typed) expected_recs.push_back(typed_rec);
		else foreach (batch[i]) expected_recs.push_back(batch[i]);
	endtask

	// receiver: random stalls plus one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = 300;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= !idle_roll();
			end
		end
	end

	function automatic void check_field(string name, logic [32:0] exp_v, logic [32:0] got_v);
		if (exp_v !== got_v) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
			errs++;
		end
	endfunction

	always @(posedge clk) begin
		rec_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = rec_t'(m_tdata[57:0]);
			if (expected_recs.size() == 0) begin
				$error("unexpected record: field_id %0d value 0x%0h", got.fid, got.val);
				errs++;
			end else begin
				want = expected_recs.pop_front();
				check_field("field_id", want.fid, got.fid);
				check_field("field_value", want.val, got.val);
				check_field("event_index", want.ev, got.ev);
				check_field("item_index", want.item, got.item);
				check_field("error_code", want.err, got.err);
				check_field("section_done", want.done, got.done);
				check_field("tdata_pad", 33'd0, m_tdata[63:58]);
			end
		end
	end

	// ---------------- section generator ----------------
	logic [7:0] sec[$];

	function automatic void put_rand(int n);
		for (int i = 0; i < n; i++) sec.push_back($urandom_range(255));
	endfunction

	function automatic void put_splice_time();
		if ($urandom_range(1)) begin
			sec.push_back({1'b1, 7'($urandom_range(127))});
			put_rand(4);
		end else begin
			sec.push_back({1'b0, 7'($urandom_range(127))});
		end
	endfunction

	function automatic void put_event(bit ins);
		bit cancel, psf, dur, imm;
		int nc;
		put_rand(4);
		cancel = ($urandom_range(4) == 0);
		sec.push_back({cancel, 7'($urandom_range(127))});
		if (!cancel) begin
			psf = $urandom_range(1);
			dur = $urandom_range(1);
			imm = $urandom_range(1);
			sec.push_back({1'($urandom_range(1)), psf, dur, imm, 4'($urandom_range(15))});
			if (!ins) imm = 1'b0;
			if (psf) begin
				if (!ins) put_rand(4);
				else if (!imm) put_splice_time();
			end else begin
				nc = $urandom_range(2);
				sec.push_back(nc);
				for (int i = 0; i < nc; i++) begin
					put_rand(1);
					if (!ins) put_rand(4);
					else if (!imm) put_splice_time();
				end
			end
			if (dur) put_rand(5);
		end
		put_rand(4);
	endfunction

	function automatic void build_section();
		bit enc;
		int kind, tier_pos, cmd_pos, loop_pos, n;
		logic [7:0]  ctype;
		logic [11:0] cmd_len, sec_len, tier;
		logic [15:0] loop_len;
		sec.delete();
		sec.push_back(($urandom_range(11) == 0) ? 8'($urandom_range(255)) : p_tid);
		sec.push_back(8'h00);
		sec.push_back(8'h00);
		put_rand(1);
		enc = ($urandom_range(3) == 0);
		sec.push_back({enc, 7'($urandom_range(127))});
		put_rand(5);
		tier_pos = sec.size();
		put_rand(3);
		kind = $urandom_range(6);
		case (kind)
			0: ctype = CMD_NULL;
			1: ctype = CMD_SCHEDULE;
			2: ctype = CMD_INSERT;
			3: ctype = CMD_TIME;
			4: ctype = CMD_BANDW;
			5: ctype = CMD_PRIVATE;
			default: begin
				do ctype = $urandom_range(255);
				while (ctype == CMD_NULL || ctype == CMD_SCHEDULE || ctype == CMD_INSERT ||
					ctype == CMD_TIME || ctype == CMD_BANDW || ctype == CMD_PRIVATE);
			end
		endcase
		sec.push_back(ctype);
		cmd_pos = sec.size();
		case (kind)
			1: begin
				n = $urandom_range(3);
				sec.push_back(n);
				for (int i = 0; i < n; i++) put_event(1'b0);
			end
			2: put_event(1'b1);
			3: put_splice_time();
			5: begin
				put_rand(4);
				if ($urandom_range(4) == 0) put_rand(0);
				else put_rand($urandom_range(3));
			end
			6: put_rand($urandom_range(4));
			default: ;
		endcase
		cmd_len = sec.size() - cmd_pos;
		if (kind == 5 && cmd_len == 4 && $urandom_range(2) == 0) cmd_len = $urandom_range(3);
		else if (kind < 5 && $urandom_range(3) == 0) cmd_len = $urandom_range(4095);
		tier = $urandom_range(4095);
		sec[tier_pos] = tier[11:4];
		sec[tier_pos + 1] = {tier[3:0], cmd_len[11:8]};
		sec[tier_pos + 2] = cmd_len[7:0];
		loop_pos = sec.size();
		put_rand(2);
		n = $urandom_range(2);
		for (int i = 0; i < n; i++) begin
			put_rand(1);
			sec.push_back($urandom_range(7));
			put_rand(sec[sec.size() - 1]);
		end
		loop_len = sec.size() - loop_pos - 2;
		if (loop_len != 0 && $urandom_range(5) == 0) loop_len = $urandom_range(loop_len - 1);
		else if ($urandom_range(19) == 0) loop_len = 16'hFFFF;
		sec[loop_pos] = loop_len[15:8];
		sec[loop_pos + 1] = loop_len[7:0];
		put_rand($urandom_range(2));
		if (enc) put_rand(4);
		put_rand(4);
		sec_len = sec.size() - 3;
		if ($urandom_range(7) == 0) sec_len = sec_len - 12'($urandom_range(1, 6));
		else if ($urandom_range(15) == 0) sec_len = sec_len + 12'($urandom_range(1, 4));
		sec[1] = {2'($urandom_range(3)), 2'($urandom_range(3)), sec_len[11:8]};
		sec[2] = sec_len[7:0];
	endfunction

	task automatic settle();
		s_tvalid <= 1'b0;
		wait (expected_recs.size() == 0);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_table_id(logic [7:0] v);
		settle();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		p_tid = v;
	endtask

	typedef struct {
		logic [7:0] b;
		logic       st;
		bit         typed;
		rec_t       r;
	} stim_row_t;

	stim_row_t stim_rows[$];

	function automatic void add_row(logic [7:0] b, logic st, bit typed = 0, rec_t r = '0);
		stim_row_t row;
		row.b = b;
		row.st = st;
		row.typed = typed;
		row.r = r;
		stim_rows.push_back(row);
	endfunction

	initial begin
		int sent, cut;
		logic [7:0] tids[4];
		clear_parse();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// wrong table id, stray byte, then an all-ones header cut by a restart
		add_row(8'h00, 1, 1, '{1'b1, ERR_TABLE_ID, 8'd0, 8'd0, 33'd0, FID_TABLE_ID});
		add_row(8'h5A, 0);
		add_row(8'hFC, 1, 1, '{1'b0, ERR_NONE, 8'd0, 8'd0, 33'h0FC, FID_TABLE_ID});
		add_row(8'hFF, 0);
		add_row(8'hFF, 0);
		add_row(8'h00, 0);
		for (int i = 0; i < 5; i++) add_row(8'hFF, 0);
		add_row(8'hFF, 0);
		add_row(8'hFF, 0);
		add_row(8'hF0, 0);
		add_row(8'h03, 0);
		add_row(CMD_INSERT, 0);
		add_row(8'hFC, 1);
		// section length 3 runs out inside the time offset field
		add_row(8'h30, 0);
		add_row(8'h03, 0);
		add_row(8'h7F, 0);
		add_row(8'h00, 0);
		add_row(8'h00, 0);
		foreach (stim_rows[i])
			send_byte(stim_rows[i].b, stim_rows[i].st, stim_rows[i].typed, stim_rows[i].r);

		tids = '{8'h00, 8'hFF, 8'($urandom_range(255)), ResetTableId};
		for (int phase = 0; phase < 4; phase++) begin
			write_table_id(tids[phase]);
			calm = (phase == 2);
			if (phase == 1) hold_req = 1'b1;
			sent = 0;
			while (sent < 75) begin
				build_section();
				cut = ($urandom_range(9) == 0) ? $urandom_range(1, sec.size() - 1) : sec.size();
				for (int i = 0; i < cut; i++) send_byte(sec[i], i == 0, 0, '0);
				sent += cut;
				if ($urandom_range(5) == 0)
					for (int i = $urandom_range(1, 3); i > 0; i--)
						send_byte($urandom_range(255), 0, 0, '0);
			end
		end
		calm = 1'b0;
		settle();
		repeat (30) @(posedge clk);
		if (errs == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

>>> sim.f
hw/rtl/sicp_pkg.sv
hw/rtl/sicp_front.sv
hw/rtl/sicp_queue.sv
hw/rtl/sicp_back.sv
hw/rtl/splice_info_section_parser_unit.sv
bench/splice_info_section_parser_unit_tb.sv
